// ===== src/dpb_pkg.sv =====
// ----------------------------------------------------------------------------
// dpb_pkg
// Shared widths, types and helpers for the depth pixel back-projection unit.
// ----------------------------------------------------------------------------
package dpb_pkg;

  localparam int IDX_W    = 12;           // pixel and centre index width
  localparam int DEPTH_W  = 24;           // depth, unsigned Q16.8
  localparam int SCALE_W  = 24;           // angle scale, unsigned Q0.24
  localparam int COORD_W  = 24;           // result coordinate, signed Q16.8
  localparam int T_W      = IDX_W + SCALE_W;   // raw tangent, Q.24
  localparam int TN_W     = 28;           // tangent after normalising
  localparam int K_W      = 4;            // normalising shift, 0..8
  localparam int K_MAX    = T_W - TN_W;   // largest shift
  localparam int ONE_SH   = 24;           // unity in Q.24
  localparam int TSQ_W    = 2 * TN_W;
  localparam int RAD_W    = 58;           // radicand, even width
  localparam int ROOT_W   = RAD_W / 2;
  localparam int PSIN_W   = DEPTH_W + TN_W;
  localparam int PCOS_W   = DEPTH_W + ONE_SH;
  localparam int NUM_W    = PSIN_W + 1;
  localparam int Q_W      = DEPTH_W;      // quotient never exceeds depth
  localparam int SUM_W    = COORD_W + 2;

  // front stages, square root, numerator add, divider, output register
  localparam int LATENCY  = 5 + ROOT_W + 1 + Q_W + 1;

  // register map, word index
  localparam logic [1:0] REG_CENTER_ROW  = 2'd0;
  localparam logic [1:0] REG_CENTER_COL  = 2'd1;
  localparam logic [1:0] REG_ANGLE_SCALE = 2'd2;
  localparam logic [1:0] REG_Z_OFFSET    = 2'd3;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // per-axis terms carried alongside the square root
  typedef struct packed {
    logic [PSIN_W-1:0] prod_sin;
    logic [PCOS_W-1:0] prod_cos;
    logic              neg;
  } axis_side_t;

  typedef struct packed {
    logic [COORD_W-1:0] val;
    logic               sat;
  } clamp_t;

  // clamp a wide signed value into a coordinate
  function automatic clamp_t clamp_coord(input logic signed [SUM_W-1:0] v);
    clamp_t res;
    if (v > SUM_W'(COORD_MAX)) begin
      res.val = COORD_MAX;
      res.sat = 1'b1;
    end else if (v < SUM_W'(COORD_MIN)) begin
      res.val = COORD_MIN;
      res.sat = 1'b1;
    end else begin
      res.val = v[COORD_W-1:0];
      res.sat = 1'b0;
    end
    return res;
  endfunction

endpackage

// ===== src/dpb_axis_front.sv =====
// ----------------------------------------------------------------------------
// dpb_axis_front
// Offset, tangent product, normalisation and squaring for one axis.
// Five register stages; also forms the depth products for the divider.
// ----------------------------------------------------------------------------
module dpb_axis_front
  import dpb_pkg::*;
#(
  parameter int COORD_WIDTH = 12
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               vld_in,
  input  logic [IDX_W-1:0]   idx,
  input  logic [IDX_W-1:0]   ctr,
  input  logic [DEPTH_W-1:0] depth,
  input  logic [SCALE_W-1:0] scale,
  output logic               vld_out,
  output logic [RAD_W-1:0]   rad,
  output axis_side_t         side
);

  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'((64'd1 << COORD_WIDTH) - 64'd1);

  // offset from centre, magnitude and sign
  logic [IDX_W-1:0]        idx_m, ctr_m, mag_c;
  logic signed [IDX_W:0]   off_c;
  logic [IDX_W:0]          off_neg;

  assign idx_m   = idx & IDX_MASK;
  assign ctr_m   = ctr & IDX_MASK;
  assign off_c   = $signed({1'b0, idx_m}) - $signed({1'b0, ctr_m});
  assign off_neg = -off_c;
  assign mag_c   = off_c[IDX_W] ? off_neg[IDX_W-1:0] : off_c[IDX_W-1:0];

  logic [4:0]         vld;
  logic [IDX_W-1:0]   mag_a;
  logic [3:0]         neg;
  logic [DEPTH_W-1:0] depth_a, depth_b, depth_c;
  logic [T_W-1:0]     t_b;
  logic [TN_W-1:0]    tn_c;
  logic [K_W-1:0]     k_c, k_d;
  logic [TSQ_W-1:0]   tsq_d;
  logic [PSIN_W-1:0]  psin_d;
  logic [PCOS_W-1:0]  pcos_d;
  logic [K_W-1:0]     k_next;
  logic [6:0]         one_sq_sh;

  // normalising shift: bring the tangent below 2^28
  always_comb begin
    k_next = '0;
    for (int i = 0; i < K_MAX; i++) begin
      if (t_b[TN_W+i]) k_next = K_W'(i + 1);
    end
  end

  assign one_sq_sh = 7'(2 * ONE_SH) - 7'({k_d, 1'b0});

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], vld_in};
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    // A: offset
    mag_a   <= mag_c;
    neg[0]  <= off_c[IDX_W];
    depth_a <= depth;
    // B: tangent product
    t_b     <= T_W'(mag_a) * T_W'(scale);
    neg[1]  <= neg[0];
    depth_b <= depth_a;
    // C: normalise
    tn_c    <= TN_W'(t_b >> k_next);
    k_c     <= k_next;
    neg[2]  <= neg[1];
    depth_c <= depth_b;
    // D: square and depth products
    tsq_d   <= TSQ_W'(tn_c) * TSQ_W'(tn_c);
    psin_d  <= PSIN_W'(depth_c) * PSIN_W'(tn_c);
    pcos_d  <= PCOS_W'(depth_c) << (ONE_SH - int'(k_c));
    k_d     <= k_c;
    neg[3]  <= neg[2];
    // E: radicand
    rad           <= RAD_W'(tsq_d) + (RAD_W'(1) << one_sq_sh);
    side.prod_sin <= psin_d;
    side.prod_cos <= pcos_d;
    side.neg      <= neg[3];
  end

  assign vld_out = vld[4];

endmodule

// ===== src/dpb_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// dpb_sqrt_pipe
// Integer square root, one root bit per register stage, with the axis terms
// carried alongside.
// ----------------------------------------------------------------------------
module dpb_sqrt_pipe
  import dpb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              vld_in,
  input  logic [RAD_W-1:0]  rad,
  input  axis_side_t        side_in,
  output logic              vld_out,
  output logic [ROOT_W-1:0] root,
  output axis_side_t        side_out
);

  localparam int N   = ROOT_W;
  localparam int RW  = ROOT_W + 2;
  localparam int EW  = RW + 2;

  logic [N:0]       vld_s;
  logic [RAD_W-1:0] rad_s  [0:N];
  logic [RW-1:0]    rem_s  [0:N];
  logic [N-1:0]     q_s    [0:N];
  axis_side_t       side_s [0:N];

  assign vld_s[0]  = vld_in;
  assign rad_s[0]  = rad;
  assign rem_s[0]  = '0;
  assign q_s[0]    = '0;
  assign side_s[0] = side_in;

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [EW-1:0] acc, trial;
    logic [RW-1:0] rem_next;
    logic [N-1:0]  q_next;

    // bring down the next two radicand bits and try the next root bit
    always_comb begin
      acc   = {rem_s[g], rad_s[g][RAD_W-1-2*g -: 2]};
      trial = EW'({q_s[g], 2'b01});
      if (acc >= trial) begin
        rem_next = RW'(acc - trial);
        q_next   = {q_s[g][N-2:0], 1'b1};
      end else begin
        rem_next = RW'(acc);
        q_next   = {q_s[g][N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[g+1] <= 1'b0;
      end else begin
        vld_s[g+1] <= vld_s[g];
      end
    end

    always_ff @(posedge clk) begin
      rad_s[g+1]  <= rad_s[g];
      rem_s[g+1]  <= rem_next;
      q_s[g+1]    <= q_next;
      side_s[g+1] <= side_s[g];
    end
  end

  assign vld_out  = vld_s[N];
  assign root     = q_s[N];
  assign side_out = side_s[N];

endmodule

// ===== src/dpb_div_pipe.sv =====
// ----------------------------------------------------------------------------
// dpb_div_pipe
// Restoring divider, one quotient bit per register stage. The numerator is
// known to be below den * 2^Q_W, so only Q_W quotient bits are formed.
// ----------------------------------------------------------------------------
module dpb_div_pipe
  import dpb_pkg::*;
(
  input  logic              clk,
  input  logic [NUM_W-1:0]  num,
  input  logic [ROOT_W-1:0] den,
  output logic [Q_W-1:0]    quo
);

  logic [NUM_W-1:0]  num_s [0:Q_W];
  logic [ROOT_W-1:0] den_s [0:Q_W];
  logic [ROOT_W-1:0] rem_s [0:Q_W];
  logic [Q_W-1:0]    q_s   [0:Q_W];

  assign num_s[0] = num;
  assign den_s[0] = den;
  assign rem_s[0] = num[NUM_W-1:Q_W];
  assign q_s[0]   = '0;

  for (genvar g = 0; g < Q_W; g++) begin : g_stage
    logic [ROOT_W:0]   acc;
    logic              ge;
    logic [ROOT_W-1:0] rem_next;

    // shift in the next numerator bit, subtract where it fits
    always_comb begin
      acc      = {rem_s[g], num_s[g][Q_W-1-g]};
      ge       = acc >= {1'b0, den_s[g]};
      rem_next = ge ? ROOT_W'(acc - {1'b0, den_s[g]}) : ROOT_W'(acc);
    end

    always_ff @(posedge clk) begin
      num_s[g+1] <= num_s[g];
      den_s[g+1] <= den_s[g];
      rem_s[g+1] <= rem_next;
      q_s[g+1]   <= {q_s[g][Q_W-2:0], ge};
    end
  end

  assign quo = q_s[Q_W];

endmodule

// ===== src/depth_pixel_backprojection_unit.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_unit
// Back-projects depth pixels to three saturated Q16.8 coordinates.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle; busy is never raised.
// The pipeline runs five front stages, the square root (one bit per stage, 29
// stages), the numerator register, the dividers (one quotient bit per stage, 24
// stages) and the output register. Zero-depth pixels give no result. Synchronous
// reset clears all valid bits and loads the register reset values; no clearing
// pass is needed.
module depth_pixel_backprojection_unit
  import dpb_pkg::*;
#(
  parameter int COORD_WIDTH = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [IDX_W-1:0]          pixel_row,
  input  logic [IDX_W-1:0]          pixel_col,
  input  logic [DEPTH_W-1:0]        depth,
  output logic                      done,
  output logic signed [COORD_W-1:0] coord_first,
  output logic signed [COORD_W-1:0] coord_second,
  output logic signed [COORD_W-1:0] coord_third,
  output logic                      saturated,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  // configuration registers
  logic [IDX_W-1:0]   center_row, center_col;
  logic [SCALE_W-1:0] angle_scale;
  logic [COORD_W-1:0] z_offset;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_row  <= IDX_W'(256);
      center_col  <= IDX_W'(256);
      angle_scale <= SCALE_W'(17560);
      z_offset    <= COORD_W'(-1280);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CENTER_ROW:  center_row  <= pwdata[IDX_W-1:0];
        REG_CENTER_COL:  center_col  <= pwdata[IDX_W-1:0];
        REG_ANGLE_SCALE: angle_scale <= pwdata[SCALE_W-1:0];
        REG_Z_OFFSET:    z_offset    <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (paddr[3:2])
      REG_CENTER_ROW:  prdata = 32'(center_row);
      REG_CENTER_COL:  prdata = 32'(center_col);
      REG_ANGLE_SCALE: prdata = 32'(angle_scale);
      REG_Z_OFFSET:    prdata = 32'(z_offset);
      default:         prdata = '0;
    endcase
  end

  // pixel beat enters every cycle; zero depth never gets a valid bit
  logic in_vld;
  assign busy   = 1'b0;
  assign in_vld = start & ~busy & (depth != '0);

  // per-axis front end
  logic               fr_vld_row;
  logic [RAD_W-1:0]   rad_row, rad_col;
  axis_side_t         fr_side_row, fr_side_col;

  dpb_axis_front #(.COORD_WIDTH(COORD_WIDTH)) u_front_row (
    .clk(clk), .rst(rst), .vld_in(in_vld),
    .idx(pixel_row), .ctr(center_row), .depth(depth), .scale(angle_scale),
    .vld_out(fr_vld_row), .rad(rad_row), .side(fr_side_row)
  );

  dpb_axis_front #(.COORD_WIDTH(COORD_WIDTH)) u_front_col (
    .clk(clk), .rst(rst), .vld_in(in_vld),
    .idx(pixel_col), .ctr(center_col), .depth(depth), .scale(angle_scale),
    .vld_out(), .rad(rad_col), .side(fr_side_col)
  );

  // square roots
  logic              sq_vld;
  logic [ROOT_W-1:0] root_row, root_col;
  axis_side_t        sq_side_row, sq_side_col;

  dpb_sqrt_pipe u_sqrt_row (
    .clk(clk), .rst(rst), .vld_in(fr_vld_row), .rad(rad_row), .side_in(fr_side_row),
    .vld_out(sq_vld), .root(root_row), .side_out(sq_side_row)
  );

  dpb_sqrt_pipe u_sqrt_col (
    .clk(clk), .rst(rst), .vld_in(fr_vld_row), .rad(rad_col), .side_in(fr_side_col),
    .vld_out(), .root(root_col), .side_out(sq_side_col)
  );

  // numerators with rounding half-divisor
  logic [NUM_W-1:0]  num_sin_row, num_sin_col, num_cos_row;
  logic [ROOT_W-1:0] den_row, den_col;
  logic              vld_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_f <= 1'b0;
    end else begin
      vld_f <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    num_sin_row <= NUM_W'(sq_side_row.prod_sin) + NUM_W'(root_row >> 1);
    num_sin_col <= NUM_W'(sq_side_col.prod_sin) + NUM_W'(root_col >> 1);
    num_cos_row <= NUM_W'(sq_side_row.prod_cos) + NUM_W'(root_row >> 1);
    den_row     <= root_row;
    den_col     <= root_col;
  end

  // signs and valid ride beside the dividers
  logic [Q_W:0] line_vld;
  logic [Q_W:0] line_neg_row, line_neg_col;
  logic         neg_row_f, neg_col_f;

  always_ff @(posedge clk) begin
    neg_row_f <= sq_side_row.neg;
    neg_col_f <= sq_side_col.neg;
  end

  assign line_vld[0]     = vld_f;
  assign line_neg_row[0] = neg_row_f;
  assign line_neg_col[0] = neg_col_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_vld[Q_W:1] <= '0;
    end else begin
      line_vld[Q_W:1] <= line_vld[Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    line_neg_row[Q_W:1] <= line_neg_row[Q_W-1:0];
    line_neg_col[Q_W:1] <= line_neg_col[Q_W-1:0];
  end

  // dividers
  logic [Q_W-1:0] q_sin_row, q_sin_col, q_cos_row;

  dpb_div_pipe u_div_sin_col (.clk(clk), .num(num_sin_col), .den(den_col), .quo(q_sin_col));
  dpb_div_pipe u_div_sin_row (.clk(clk), .num(num_sin_row), .den(den_row), .quo(q_sin_row));
  dpb_div_pipe u_div_cos_row (.clk(clk), .num(num_cos_row), .den(den_row), .quo(q_cos_row));

  // sign, z offset and clamping
  logic signed [SUM_W-1:0] v_first, v_second, v_third;
  clamp_t                  c_first, c_second, c_third;

  always_comb begin
    v_first  = line_neg_col[Q_W] ? -$signed(SUM_W'(q_sin_col)) : $signed(SUM_W'(q_sin_col));
    v_second = line_neg_row[Q_W] ? -$signed(SUM_W'(q_sin_row)) : $signed(SUM_W'(q_sin_row));
    v_third  = $signed(SUM_W'(q_cos_row)) + SUM_W'($signed(z_offset));
    c_first  = clamp_coord(v_first);
    c_second = clamp_coord(v_second);
    c_third  = clamp_coord(v_third);
  end

  // result register, strobe for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= line_vld[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    coord_first  <= c_first.val;
    coord_second <= c_second.val;
    coord_third  <= c_third.val;
    saturated    <= c_first.sat | c_second.sat | c_third.sat;
  end

endmodule

// ===== src/dpb_checker.sv =====
// ----------------------------------------------------------------------------
// dpb_checker
// Port-level checks on the back-projection unit, bound to the top level.
// ----------------------------------------------------------------------------
module dpb_checker
  import dpb_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic [DEPTH_W-1:0]        depth,
  input logic                      done,
  input logic signed [COORD_W-1:0] coord_first,
  input logic signed [COORD_W-1:0] coord_second,
  input logic signed [COORD_W-1:0] coord_third,
  input logic                      saturated,
  input logic                      psel,
  input logic                      penable,
  input logic                      pwrite,
  input logic [3:0]                paddr,
  input logic [31:0]               pwdata,
  input logic [31:0]               prdata,
  input logic                      pready
);

  // every non-zero pixel beat yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && depth != '0) |-> ##LATENCY done)
    else $error("pixel beat gave no result");

  // no result without a non-zero pixel beat at the fixed latency before
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && depth != '0, LATENCY))
    else $error("result without a pixel beat");

  // a saturated result has at least one coordinate at a range limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |->
      (coord_first == COORD_MAX || coord_first == COORD_MIN ||
       coord_second == COORD_MAX || coord_second == COORD_MIN ||
       coord_third == COORD_MAX || coord_third == COORD_MIN))
    else $error("saturated flag without a clamped coordinate");

  // a written angle scale reads back at once when addressed again
  a_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[3:2] == REG_ANGLE_SCALE) |=>
      (paddr[3:2] != REG_ANGLE_SCALE || prdata == 32'($past(pwdata[SCALE_W-1:0]))))
    else $error("angle scale read-back mismatch");

endmodule

bind depth_pixel_backprojection_unit dpb_checker u_dpb_checker (.*);
